/* rtl/xvbd_pkg.sv */
// Shared types, constants and the round mixing function of the XTEA-variant decryptor.
`timescale 1ns / 1ps

package xvbd_pkg;

    localparam logic [31:0] DELTA      = 32'h9E37_79B9;
    localparam int          KEY_WORDS  = 4;
    localparam int          CFG_IDX_W  = 8;
    localparam int          WORD_W     = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = CFG_IDX_W'(3);

    typedef struct packed {
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
    } t_block;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    function automatic logic [WORD_W-1:0] mix_term(
        input logic [WORD_W-1:0] half,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] kw
    );
        return (half ^ sum) + kw + ((half << 4) ^ (half >> 5));
    endfunction

endpackage

/* rtl/xvbd_front.sv */
// Front end: accepts ciphertext requests into a two-entry queue ahead of the round pipeline.
`timescale 1ns / 1ps

module xvbd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  xvbd_pkg::t_block     i_in_block,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output xvbd_pkg::t_block     o_q_block
);

    xvbd_pkg::t_block r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count,  n_count;
    logic             w_push, w_pop;

    assign o_in_ready = (r_count != 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_block  = r_mem[r_rd_ptr];

    assign w_push = i_in_valid && o_in_ready;
    assign w_pop  = o_q_valid && i_q_ready;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_in_block;
        end
    end

endmodule

/* rtl/xvbd_back.sv */
// Back end: unrolled round pipeline, one half-round per stage, last stage is the output register.
`timescale 1ns / 1ps

module xvbd_back #(
    parameter int ROUND_COUNT = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  xvbd_pkg::t_key       i_key,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  xvbd_pkg::t_block     i_q_block,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output xvbd_pkg::t_block     o_out_block
);

    localparam int STAGES = 2 * ROUND_COUNT;

    xvbd_pkg::t_block r_data [STAGES];
    logic [STAGES-1:0] r_vld;
    logic              w_adv;

    // The whole pipeline moves together unless the result is held.
    assign w_adv       = !r_vld[STAGES-1] || i_out_ready;
    assign o_q_ready   = w_adv;
    assign o_out_valid = r_vld[STAGES-1];
    assign o_out_block = r_data[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_q_valid};
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam int          RND     = g / 2;
        localparam logic [63:0] PROD_B  = 64'(ROUND_COUNT - RND) * 64'(xvbd_pkg::DELTA);
        localparam logic [63:0] PROD_A  = 64'(ROUND_COUNT - RND - 1) * 64'(xvbd_pkg::DELTA);
        localparam logic [31:0] SUM_B   = PROD_B[31:0];
        localparam logic [31:0] SUM_A   = PROD_A[31:0];

        xvbd_pkg::t_block w_src;
        xvbd_pkg::t_block w_res;

        if (g == 0) begin : g_head
            assign w_src = i_q_block;
        end else begin : g_body
            assign w_src = r_data[g-1];
        end

        if ((g % 2) == 0) begin : g_second
            // second half falls, key chosen from bits 12..11 of the sum before it falls
            always_comb begin
                w_res        = w_src;
                w_res.second = w_src.second
                             - xvbd_pkg::mix_term(w_src.first, SUM_B, i_key[SUM_B[12:11]]);
            end
        end else begin : g_first
            always_comb begin
                w_res       = w_src;
                w_res.first = w_src.first
                            - xvbd_pkg::mix_term(w_src.second, SUM_A, i_key[SUM_A[1:0]]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_data[g] <= w_res;
            end
        end
    end

endmodule

/* rtl/xtea_variant_block_decrypt.sv */
// Top level of the XTEA-variant block decryptor: key registers, request queue and round pipeline.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one 64-bit ciphertext block as
//   i_cipher_first and i_cipher_second. Output channel (o_out_valid / i_out_ready)
//   returns o_plain_first and o_plain_second, one result per request, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes key word i_cfg_index
//   (0..3) with i_cfg_data; other indexes are dropped. Write keys only while idle.
//   Each request passes from the queue head into the first half-round stage and
//   then through one register per half-round to the output.
//   Throughput: one block per cycle unless the receiver stalls, set by the fully unrolled round pipeline.
//   When the receiver stalls, the pipeline holds as a whole; the front queue
//   keeps taking up to two more requests before o_in_ready drops.
//   Reset (synchronous, active low) clears the keys to zero and empties the
//   queue and pipeline; requests are taken on the first cycle after reset.
`timescale 1ns / 1ps

module xtea_variant_block_decrypt #(
    parameter int ROUND_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_cipher_first,
    input  logic [31:0] i_cipher_second,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_plain_first,
    output logic [31:0] o_plain_second,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    xvbd_pkg::t_key   r_key;
    xvbd_pkg::t_block w_in_block;
    xvbd_pkg::t_block w_q_block;
    xvbd_pkg::t_block w_out_block;
    logic             w_q_valid;
    logic             w_q_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                xvbd_pkg::CFG_KEY_WORD0: r_key[0] <= i_cfg_data;
                xvbd_pkg::CFG_KEY_WORD1: r_key[1] <= i_cfg_data;
                xvbd_pkg::CFG_KEY_WORD2: r_key[2] <= i_cfg_data;
                xvbd_pkg::CFG_KEY_WORD3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in_block.first  = i_cipher_first;
    assign w_in_block.second = i_cipher_second;

    xvbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_block (w_in_block),
        .o_q_valid  (w_q_valid),
        .i_q_ready  (w_q_ready),
        .o_q_block  (w_q_block)
    );

    xvbd_back #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (r_key),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .i_q_block   (w_q_block),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_block (w_out_block)
    );

    assign o_plain_first  = w_out_block.first;
    assign o_plain_second = w_out_block.second;

endmodule

/* rtl/xvbd_checker.sv */
// Port-level checker for the XTEA-variant block decryptor, bound to the top level.
`timescale 1ns / 1ps

module xvbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_plain_first,
    input logic [31:0] o_plain_second,
    input logic        o_cfg_ready
);

    // Reset must empty the pipeline by the next cycle.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result still valid after reset");

    // Key writes are never back-pressured outside reset.
    a_cfg_open: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) o_cfg_ready)
        else $error("configuration channel stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_plain_first) && $stable(o_plain_second))
        else $error("result changed while stalled");

endmodule

bind xtea_variant_block_decrypt xvbd_checker u_xvbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_plain_first  (o_plain_first),
    .o_plain_second (o_plain_second),
    .o_cfg_ready    (o_cfg_ready)
);

/* verif/tb.sv */
// Self-checking testbench for the XTEA-variant block decryptor.
`timescale 1ns / 1ps

module tb;

    localparam int          ROUNDS       = 32;
    localparam logic [31:0] GOLDEN_DELTA = 32'h9E37_79B9;
    localparam int          PIPE_CYCLES  = 2 * ROUNDS + 1;
    localparam int          SETTLE_WAIT  = 3 * PIPE_CYCLES;
    localparam int          CYCLE_LIMIT  = 200_000;
    localparam int          GAP_PERCENT  = 20;
    localparam int          HOLD_CYCLES  = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_cipher_first;
    logic [31:0] i_cipher_second;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_plain_first;
    logic [31:0] o_plain_second;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    xvbd_pkg::t_key   key_model;
    xvbd_pkg::t_block plain_expected[$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     gaps_on     = 1'b1;
    int     hold_len    = 0;
    int     hold_count  = 0;

    xtea_variant_block_decrypt #(.ROUND_COUNT(ROUNDS)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] half_round_term(logic [31:0] half, logic [31:0] sum,
                                                    logic [31:0] key_word);
        return (half ^ sum) + key_word + ((half << 4) ^ (half >> 5));
    endfunction

    // Walk the sum down from ROUNDS * delta; the second half is undone first.
    function automatic xvbd_pkg::t_block decrypt_block(xvbd_pkg::t_block ct,
                                                       xvbd_pkg::t_key key);
        logic [31:0] first;
        logic [31:0] second;
        logic [31:0] sum;
        first  = ct.first;
        second = ct.second;
        sum    = 32'(ROUNDS) * GOLDEN_DELTA;
        for (int r = 0; r < ROUNDS; r++) begin
            second -= half_round_term(first, sum, key[sum[12:11]]);
            sum    -= GOLDEN_DELTA;
            first  -= half_round_term(second, sum, key[sum[1:0]]);
        end
        return '{first: first, second: second};
    endfunction

    function automatic bit take_gap();
        return gaps_on && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    // Receiver: honor a requested hold first, then stall at random.
    always @(negedge i_clk) begin
        if (hold_count < hold_len) begin
            i_out_ready <= 1'b0;
            hold_count++;
        end else begin
            i_out_ready <= !take_gap();
        end
    end

    always @(posedge i_clk) begin
        xvbd_pkg::t_block want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (plain_expected.size() == 0) begin
                $error("plain block with no request pending: %h %h",
                       o_plain_first, o_plain_second);
                error_count++;
            end else begin
                want = plain_expected.pop_front();
                if (o_plain_first !== want.first) begin
                    $error("plain_first: expected %h, got %h", want.first, o_plain_first);
                    error_count++;
                end
                if (o_plain_second !== want.second) begin
                    $error("plain_second: expected %h, got %h", want.second, o_plain_second);
                    error_count++;
                end
            end
        end
    end

    // Hold valid and payload until the request is taken; leave valid high afterwards.
    task send_block(input xvbd_pkg::t_block ct);
        @(negedge i_clk);
        while (take_gap()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cipher_first  <= ct.first;
        i_cipher_second <= ct.second;
        do @(posedge i_clk); while (!o_in_ready);
        plain_expected.push_back(decrypt_block(ct, key_model));
    endtask

    task send_random_blocks(input int count);
        for (int n = 0; n < count; n++)
            send_block('{first: $urandom, second: $urandom});
    endtask

    task send_corner_blocks();
        send_block('{first: 32'h0000_0000, second: 32'h0000_0000});
        send_block('{first: 32'hFFFF_FFFF, second: 32'hFFFF_FFFF});
        send_block('{first: 32'h0000_0000, second: 32'hFFFF_FFFF});
        send_block('{first: 32'hFFFF_FFFF, second: 32'h0000_0000});
        send_block('{first: 32'h8000_0000, second: 32'h0000_0001});
        send_block('{first: 32'h5555_5555, second: 32'hAAAA_AAAA});
    endtask

    // Drop valid, then wait for every pending result.
    task wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (plain_expected.size() != 0) @(posedge i_clk);
    endtask

    task write_key_word(input logic [7:0] index, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index < xvbd_pkg::KEY_WORDS)
            key_model[index[1:0]] = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task load_key(input xvbd_pkg::t_key key);
        write_key_word(xvbd_pkg::CFG_KEY_WORD0, key[0]);
        write_key_word(xvbd_pkg::CFG_KEY_WORD1, key[1]);
        write_key_word(xvbd_pkg::CFG_KEY_WORD2, key[2]);
        write_key_word(xvbd_pkg::CFG_KEY_WORD3, key[3]);
    endtask

    task test_reset_key();
        send_corner_blocks();
        wait_results_drained();
    endtask

    task test_key_extremes();
        load_key({4{32'hFFFF_FFFF}});
        send_corner_blocks();
        wait_results_drained();
        load_key({32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
        send_random_blocks(3);
        wait_results_drained();
    endtask

    // Writes above the last key word must leave the key alone.
    task test_ignored_index();
        write_key_word(8'hFF, $urandom);
        write_key_word(8'(xvbd_pkg::KEY_WORDS), $urandom);
        write_key_word(8'($urandom_range(255, xvbd_pkg::KEY_WORDS)), $urandom);
        send_random_blocks(3);
        wait_results_drained();
    endtask

    task test_random_blocks();
        load_key({$urandom, $urandom, $urandom, $urandom});
        send_random_blocks(150);
        wait_results_drained();
    endtask

    task test_no_gaps();
        gaps_on = 1'b0;
        send_random_blocks(100);
        wait_results_drained();
        gaps_on = 1'b1;
    endtask

    // Stall the receiver long enough for the queue and pipeline to fill.
    task test_backpressure();
        gaps_on = 1'b0;
        @(posedge i_clk);
        hold_len = HOLD_CYCLES;
        send_random_blocks(100);
        gaps_on = 1'b1;
        wait_results_drained();
    endtask

    task test_rekey();
        load_key({32'hFFFF_FFFF, $urandom, 32'h0000_0000, $urandom});
        send_random_blocks(50);
        wait_results_drained();
        load_key({$urandom, 32'h0000_0000, $urandom, 32'hFFFF_FFFF});
        send_random_blocks(50);
        wait_results_drained();
        load_key({$urandom, $urandom, $urandom, $urandom});
        send_random_blocks(50);
        wait_results_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_cipher_first  = '0;
        i_cipher_second = '0;
        i_out_ready     = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        key_model       = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_key();
        test_key_extremes();
        test_ignored_index();
        test_random_blocks();
        test_no_gaps();
        test_backpressure();
        test_rekey();

        wait_results_drained();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (error_count == 0 && plain_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
